>>> design/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, status codes and controller/datapath handshake structs for
// the sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int DATA_W    = 32;
	localparam int STATUS_W  = 2;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [STATUS_W-1:0]      status_t;

	localparam status_t ST_DONE      = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	localparam data_t NO_VALUE = '1;

	typedef struct packed {
		data_t pri;
		data_t val;
	} entry_t;

	typedef struct packed {
		logic capture;
		logic place_first;
		logic set_overflow;
		logic set_underflow;
		logic start_shift;
		logic shift_step;
		logic place_new;
		logic rd_front;
		logic pop_commit;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic empty;
		logic full;
		logic ins_next_front;
		logic older_less;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

>>> design/spq_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_if
// Valid/ready channel interfaces for queue requests and queue responses.
// ----------------------------------------------------------------------------
interface spq_in_if import spq_pkg::*; ();
	logic  valid;
	logic  ready;
	logic  mode;
	data_t value;
	data_t priority_req;

	modport source (output valid, output mode, output value, output priority_req,
		input ready);
	modport sink (input valid, input mode, input value, input priority_req,
		output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
	logic    valid;
	logic    ready;
	data_t   popped_value;
	status_t status;

	modport source (output valid, output popped_value, output status, input ready);
	modport sink (input valid, input popped_value, input status, output ready);
endinterface

`default_nettype wire

>>> design/sorted_priority_queue_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// Priority queue kept sorted by descending priority in an entry RAM; equal
// priorities leave in arrival order. Overflow and underflow are reported.
// ----------------------------------------------------------------------------
// one request in flight; a pop reads the front entry in dispatch, commits it in pop and responds from done
// a push shifts back each entry of lower priority, then places the new entry
// a push into an empty queue, an overflow or an underflow goes from dispatch to done
// the insertion walk moves one entry per cycle
// a new request is taken in idle; a stalled response holds off the next one
// reset clears indexes and marks the queue empty; the entry ram is not cleared
module sorted_priority_queue_core import spq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	spq_in_if.sink    req,
	spq_out_if.source rsp
);

	cmd_t  cmd;
	stat_t st;

	spq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(req.ready),
		.st      (st),
		.cmd     (cmd)
	);

	spq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.st          (st),
		.req_mode    (req.mode),
		.req_value   (req.value),
		.req_priority(req.priority_req),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.out_value   (rsp.popped_value),
		.out_status  (rsp.status)
	);

endmodule

`default_nettype wire

>>> design/spq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output      logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

>>> design/spq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Controller for the sorted priority queue: sequences request dispatch,
// insertion shifting, pop readout and response handoff.
// ----------------------------------------------------------------------------
module spq_ctrl import spq_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output      logic  in_ready,
	input  wire stat_t st,
	output      cmd_t  cmd
);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_DISPATCH = 3'd1;
	localparam logic [2:0] S_SHIFT    = 3'd2;
	localparam logic [2:0] S_PLACE    = 3'd3;
	localparam logic [2:0] S_POP      = 3'd4;
	localparam logic [2:0] S_DONE     = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				if (st.mode == MODE_PUSH) begin
					if (st.empty) begin
						cmd.place_first = 1'b1;
						state_d         = S_DONE;
					end else if (st.full) begin
						cmd.set_overflow = 1'b1;
						state_d          = S_DONE;
					end else begin
						cmd.start_shift = 1'b1;
						state_d         = S_SHIFT;
					end
				end else begin
					if (st.empty) begin
						cmd.set_underflow = 1'b1;
						state_d           = S_DONE;
					end else begin
						cmd.rd_front = 1'b1;
						state_d      = S_POP;
					end
				end
			end
			S_SHIFT: begin
				if (st.older_less) begin
					cmd.shift_step = 1'b1;
					if (st.ins_next_front) begin
						state_d = S_PLACE;
					end
				end else begin
					cmd.place_new = 1'b1;
					state_d       = S_DONE;
				end
			end
			S_PLACE: begin
				cmd.place_new = 1'b1;
				state_d       = S_DONE;
			end
			S_POP: begin
				cmd.pop_commit = 1'b1;
				state_d        = S_DONE;
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

>>> design/spq_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_dp
// Datapath for the sorted priority queue: request registers, front/rear
// indexes, entry RAM, insertion shift pointer and response register.
// ----------------------------------------------------------------------------
module spq_dp import spq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire cmd_t    cmd,
	output      stat_t   st,
	input  wire logic    req_mode,
	input  wire data_t   req_value,
	input  wire data_t   req_priority,
	output      logic    out_valid,
	input  wire logic    out_ready,
	output      data_t   out_value,
	output      status_t out_status
);

	localparam int IW = $clog2(DEPTH);
	localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

	logic          mode_q;
	data_t         val_q;
	data_t         pri_q;
	logic [IW-1:0] front_q;
	logic [IW-1:0] rear_q;
	logic          empty_q;
	logic [IW-1:0] ins_q;
	data_t         res_val_q;
	status_t       res_st_q;
	logic          out_valid_q;
	data_t         out_val_q;
	status_t       out_st_q;

	logic          wr_en;
	logic [IW-1:0] wr_addr;
	entry_t        wr_data;
	logic          rd_en;
	logic [IW-1:0] rd_addr;
	entry_t        rd_data;
	logic [IW-1:0] ins_m1;
	logic [IW-1:0] ins_m2;
	entry_t        new_entry;

	assign ins_m1    = ins_q - IW'(1);
	assign ins_m2    = ins_q - IW'(2);
	assign new_entry = '{pri: pri_q, val: val_q};

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = ins_q;
		wr_data = new_entry;
		if (cmd.place_first) begin
			wr_en   = 1'b1;
			wr_addr = '0;
		end else if (cmd.shift_step) begin
			wr_en   = 1'b1;
			wr_data = rd_data;
		end else if (cmd.place_new) begin
			wr_en = 1'b1;
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ins_m2;
		if (cmd.start_shift) begin
			rd_en   = 1'b1;
			rd_addr = rear_q;
		end else if (cmd.rd_front) begin
			rd_en   = 1'b1;
			rd_addr = front_q;
		end else if (cmd.shift_step && (ins_m1 != front_q)) begin
			rd_en = 1'b1;
		end
	end

	spq_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(DEPTH)
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign st.mode           = mode_q;
	assign st.empty          = empty_q;
	assign st.full           = (rear_q == LAST);
	assign st.ins_next_front = (ins_m1 == front_q);
	assign st.older_less     = (rd_data.pri < pri_q);
	assign st.out_free       = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= req_mode;
			val_q  <= req_value;
			pri_q  <= req_priority;
		end
		if (cmd.start_shift) begin
			ins_q <= rear_q + IW'(1);
		end else if (cmd.shift_step) begin
			ins_q <= ins_m1;
		end
		if (cmd.place_first || cmd.place_new) begin
			res_val_q <= NO_VALUE;
			res_st_q  <= ST_DONE;
		end else if (cmd.set_overflow) begin
			res_val_q <= NO_VALUE;
			res_st_q  <= ST_OVERFLOW;
		end else if (cmd.set_underflow) begin
			res_val_q <= NO_VALUE;
			res_st_q  <= ST_UNDERFLOW;
		end else if (cmd.pop_commit) begin
			res_val_q <= rd_data.val;
			res_st_q  <= ST_DONE;
		end
		if (cmd.out_load) begin
			out_val_q <= res_val_q;
			out_st_q  <= res_st_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q     <= '0;
			rear_q      <= '0;
			empty_q     <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.place_first) begin
				front_q <= '0;
				rear_q  <= '0;
				empty_q <= 1'b0;
			end else if (cmd.place_new) begin
				rear_q <= rear_q + IW'(1);
			end else if (cmd.pop_commit) begin
				if (front_q == rear_q) begin
					front_q <= '0;
					rear_q  <= '0;
					empty_q <= 1'b1;
				end else begin
					front_q <= front_q + IW'(1);
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_value  = out_val_q;
	assign out_status = out_st_q;

	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (front_q == '0 && rear_q == '0))
		else $error("empty queue with nonzero indexes");

	a_order_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!empty_q |-> (front_q <= rear_q))
		else $error("front index past rear index");

	a_shift_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.shift_step |-> (ins_q > front_q && ins_q <= LAST))
		else $error("insertion shift outside occupied range");

	a_place_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.place_new |-> (!empty_q && rear_q < LAST))
		else $error("insert into full or empty queue");

endmodule

`default_nettype wire

>>> tb/sv/sorted_priority_queue_core_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_core_tb
// Drives push and pop requests into the sorted priority queue and checks every
// response against a cycle-free model of the queue that runs in the bench.
// Directed runs hit empty pops, extreme values and priorities, equal-priority
// ordering and overflow; random runs fill and drain the queue under several
// idle and stall patterns, including one long response hold-off.
// ----------------------------------------------------------------------------
module sorted_priority_queue_core_tb;
	import spq_pkg::*;

	localparam int Q_DEPTH    = DEPTH_DEF;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_LEN   = 300;
	localparam int END_WAIT   = 4 * (Q_DEPTH + 2);
	localparam int MAX_PRINTS = 60;

	localparam data_t VAL_MAX = 32'sh7fff_ffff;
	localparam data_t VAL_MIN = 32'sh8000_0000;

	typedef struct {
		data_t   popped;
		status_t st;
	} rsp_t;

	logic clk;
	logic arst_n;
	logic rsp_ready = 1'b0;

	spq_in_if  req_if ();
	spq_out_if rsp_if ();

	assign rsp_if.ready = rsp_ready;

	sorted_priority_queue_core #(.DEPTH(Q_DEPTH)) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if.sink),
		.rsp    (rsp_if.source)
	);

	// queue contents as the bench sees them
	data_t q_val [Q_DEPTH];
	data_t q_pri [Q_DEPTH];
	int    q_front;
	int    q_rear;
	bit    q_empty;

	rsp_t expected_rsp [$];
	int   err_cnt = 0;
	int   send_idle_pct = 0;
	int   stall_pct = 0;
	bit   hold_trig = 1'b0;
	bit   hold_seen = 1'b0;
	int   hold_left = 0;
	int   idle_cnt = 0;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	task automatic report_mismatch(string what, data_t got, data_t want);
		if (err_cnt < MAX_PRINTS)
			$display("mismatch %s: got %h expected %h", what, got, want);
		err_cnt++;
	endtask

	function automatic rsp_t apply_request(logic mode, data_t value, data_t pri);
		rsp_t r;
		int   pos;
		r.popped = NO_VALUE;
		r.st     = ST_DONE;
		if (mode == MODE_PUSH) begin
			if (q_empty) begin
				q_front  = 0;
				q_rear   = 0;
				q_val[0] = value;
				q_pri[0] = pri;
				q_empty  = 1'b0;
			end else if (q_rear >= Q_DEPTH - 1) begin
				r.st = ST_OVERFLOW;
			end else begin
				pos = q_rear;
				while (pos >= q_front && q_pri[pos] < pri) begin
					q_val[pos + 1] = q_val[pos];
					q_pri[pos + 1] = q_pri[pos];
					pos--;
				end
				q_val[pos + 1] = value;
				q_pri[pos + 1] = pri;
				q_rear++;
			end
		end else if (q_empty) begin
			r.st = ST_UNDERFLOW;
		end else begin
			r.popped = q_val[q_front];
			q_front++;
			if (q_front > q_rear) begin
				q_front = 0;
				q_rear  = 0;
				q_empty = 1'b1;
			end
		end
		return r;
	endfunction

	// called and returns at a rising edge
	task automatic issue_request(logic mode, data_t value, data_t pri);
		int gap;
		req_if.valid        <= 1'b1;
		req_if.mode         <= mode;
		req_if.value        <= value;
		req_if.priority_req <= pri;
		do
			@(posedge clk);
		while (!(req_if.valid && req_if.ready));
		expected_rsp.push_back(apply_request(mode, value, pri));
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		stall_pct     = recv_pct;
	endtask

	task automatic wait_drained();
		req_if.valid <= 1'b0;
		while (expected_rsp.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_empty_pops();
		issue_request(MODE_POP, VAL_MIN, VAL_MAX);
		issue_request(MODE_PUSH, VAL_MAX, VAL_MIN);
		issue_request(MODE_POP, 32'sd0, 32'sd0);
		issue_request(MODE_POP, VAL_MAX, VAL_MIN);
	endtask

	task automatic test_fill_order_overflow();
		data_t pris [Q_DEPTH];
		pris = '{32'sd0, VAL_MAX, VAL_MIN, 32'sd5, 32'sd5, -32'sd1, VAL_MAX, 32'sd0};
		for (int i = 0; i < Q_DEPTH; i++)
			issue_request(MODE_PUSH, (i == 0) ? VAL_MIN : data_t'(i * 32'h1111_1111), pris[i]);
		// full: rear at the last slot
		issue_request(MODE_PUSH, VAL_MAX, VAL_MAX);
		for (int i = 0; i < Q_DEPTH; i++)
			issue_request(MODE_POP, 32'sd0, 32'sd0);
	endtask

	task automatic test_backpressure();
		set_idling(0, 0);
		wait_drained();
		hold_trig <= ~hold_trig;
		for (int i = 0; i < 12; i++)
			issue_request((i % 3 == 2) ? MODE_POP : MODE_PUSH, data_t'($urandom),
				data_t'($urandom_range(7)));
	endtask

	task automatic test_sender_pause();
		set_idling(0, 30);
		for (int i = 0; i < 5; i++)
			issue_request(MODE_PUSH, data_t'($urandom), data_t'($urandom_range(3)));
		req_if.valid <= 1'b0;
		wait_drained();
		@(posedge clk);
		for (int i = 0; i < 6; i++)
			issue_request(MODE_POP, data_t'($urandom), data_t'($urandom));
	endtask

	task automatic test_random_traffic(int n, int send_pct, int recv_pct);
		bit    filling;
		logic  mode;
		data_t pri;
		filling = 1'b1;
		set_idling(send_pct, recv_pct);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(11) == 0)
				filling = ~filling;
			if ($urandom_range(19) == 0)
				mode = logic'($urandom_range(1));
			else
				mode = ($urandom_range(99) < (filling ? 80 : 25)) ? MODE_PUSH : MODE_POP;
			if ($urandom_range(1) == 0)
				pri = data_t'($urandom_range(4)) - 32'sd2;
			else
				pri = data_t'($urandom);
			issue_request(mode, data_t'($urandom), pri);
		end
	endtask

	// response side: check each transfer, then decide ready for the next edge
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_if.valid && rsp_ready) begin
			if (expected_rsp.size() == 0) begin
				report_mismatch("unexpected response", rsp_if.popped_value, NO_VALUE);
			end else begin
				want = expected_rsp.pop_front();
				if (rsp_if.popped_value !== want.popped)
					report_mismatch("popped_value", rsp_if.popped_value, want.popped);
				if (rsp_if.status !== want.st)
					report_mismatch("status", data_t'(rsp_if.status), data_t'(want.st));
			end
		end
		if (hold_trig != hold_seen) begin
			hold_seen <= hold_trig;
			hold_left <= HOLD_LEN;
			rsp_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_ready)) begin
				idle_cnt <= 0;
			end else if (idle_cnt >= IDLE_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end else begin
				idle_cnt <= idle_cnt + 1;
			end
		end
	end

	initial begin
		arst_n              = 1'b0;
		req_if.valid        = 1'b0;
		req_if.mode         = MODE_PUSH;
		req_if.value        = '0;
		req_if.priority_req = '0;
		q_front             = 0;
		q_rear              = 0;
		q_empty             = 1'b1;
		for (int i = 0; i < Q_DEPTH; i++) begin
			q_val[i] = '0;
			q_pri[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(0, 0);
		test_empty_pops();
		test_fill_order_overflow();
		test_backpressure();
		test_sender_pause();
		test_random_traffic(220, 0, 0);
		test_random_traffic(210, 69, 0);
		test_random_traffic(210, 0, 69);
		test_random_traffic(210, 10, 10);

		req_if.valid <= 1'b0;
		wait_drained();
		repeat (END_WAIT) @(posedge clk);
		if (err_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

`default_nettype wire

>>> sorted_priority_queue_core.f
design/spq_pkg.sv
design/spq_if.sv
design/spq_ram.sv
design/spq_ctrl.sv
design/spq_dp.sv
design/sorted_priority_queue_core.sv
tb/sv/sorted_priority_queue_core_tb.sv
